FILE: sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Beat types and fixed datapath widths shared by the normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int CoordW = 16;
    localparam int DiffW  = CoordW + 1;
    localparam int ProdW  = 2 * DiffW;
    localparam int MagW   = 2 * CoordW + 2;
    localparam int HalfW  = (MagW + 1) / 2;
    localparam int SqW    = 2 * MagW;
    localparam int SumW   = SqW + 2;
    localparam int RootW  = SumW / 2;
    localparam int OutW   = 16;

    typedef struct packed {
        logic signed [CoordW-1:0] vertex0_x;
        logic signed [CoordW-1:0] vertex0_y;
        logic signed [CoordW-1:0] vertex0_z;
        logic signed [CoordW-1:0] vertex1_x;
        logic signed [CoordW-1:0] vertex1_y;
        logic signed [CoordW-1:0] vertex1_z;
        logic signed [CoordW-1:0] vertex2_x;
        logic signed [CoordW-1:0] vertex2_y;
        logic signed [CoordW-1:0] vertex2_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [OutW-1:0] normal_x;
        logic signed [OutW-1:0] normal_y;
        logic signed [OutW-1:0] normal_z;
        logic                   degenerate;
    } t_out_beat;

    typedef struct packed {
        logic [2:0][MagW-1:0] mag;
        logic [2:0]           neg;
        logic                 zero;
    } t_side;

endpackage

FILE: sv/triangle_unit_normal_top.sv
// ----------------------------------------------------------------------------
// Triangle unit normal
// A beat passes through the difference register, the cross product lanes, the sum
// register, the root stages, the divider stages and the output register. A new
// beat is taken every cycle, so busy never rises. Reset clears only the valid
// pipeline; the receiver cannot stall, and each result is strobed for exactly one cycle.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tun_pkg::t_in_beat  i_in,
    output logic               o_valid,
    output tun_pkg::t_out_beat o_out
);
    localparam int DW  = tun_pkg::DiffW;
    localparam int MW  = tun_pkg::MagW;
    localparam int QW  = tun_pkg::SqW;
    localparam int SW  = tun_pkg::SumW;
    localparam int LW  = tun_pkg::RootW;
    localparam int OW  = tun_pkg::OutW;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int LAT = 1 + 4 + 1 + LW + (F + 1) + 1;

    logic [LAT-1:0]         r_vld;
    logic signed [DW-1:0]   r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [2:0][MW-1:0]     mag;
    logic [2:0]             neg;
    logic [2:0][QW-1:0]     sq;
    logic [SW-1:0]          r_s;
    tun_pkg::t_side         r_side;
    tun_pkg::t_side         root_side;
    logic [LW-1:0]          root;
    logic [2:0][F:0]        quo;
    logic [2:0]             qneg;
    logic [F:0]             r_zero_dly;
    logic [2:0][OW-1:0]     comp;
    tun_pkg::t_out_beat     r_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax <= DW'(i_in.vertex0_x) - DW'(i_in.vertex1_x);
        r_ay <= DW'(i_in.vertex0_y) - DW'(i_in.vertex1_y);
        r_az <= DW'(i_in.vertex0_z) - DW'(i_in.vertex1_z);
        r_bx <= DW'(i_in.vertex1_x) - DW'(i_in.vertex2_x);
        r_by <= DW'(i_in.vertex1_y) - DW'(i_in.vertex2_y);
        r_bz <= DW'(i_in.vertex1_z) - DW'(i_in.vertex2_z);
    end

    tun_cross u_cross_x (.i_clk(i_clk), .i_x1(r_ay), .i_y1(r_bz), .i_x2(r_az), .i_y2(r_by),
                         .o_mag(mag[0]), .o_neg(neg[0]), .o_sq(sq[0]));
    tun_cross u_cross_y (.i_clk(i_clk), .i_x1(r_az), .i_y1(r_bx), .i_x2(r_ax), .i_y2(r_bz),
                         .o_mag(mag[1]), .o_neg(neg[1]), .o_sq(sq[1]));
    tun_cross u_cross_z (.i_clk(i_clk), .i_x1(r_ax), .i_y1(r_by), .i_x2(r_ay), .i_y2(r_bx),
                         .o_mag(mag[2]), .o_neg(neg[2]), .o_sq(sq[2]));

    always_ff @(posedge i_clk) begin
        r_s         <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
        r_side.mag  <= mag;
        r_side.neg  <= neg;
        r_side.zero <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
    end

    tun_sqrt u_sqrt (.i_clk(i_clk), .i_s(r_s), .i_side(r_side),
                     .o_root(root), .o_side(root_side));

    for (genvar k = 0; k < 3; k++) begin : g_div
        tun_div #(.FRAC(F)) u_div (
            .i_clk (i_clk),
            .i_mag (root_side.mag[k]),
            .i_len (root),
            .i_neg (root_side.neg[k]),
            .o_q   (quo[k]),
            .o_neg (qneg[k])
        );

        logic [31:0] qx;
        assign qx = 32'(quo[k]);

        always_comb begin
            if (qneg[k]) begin
                comp[k] = (qx > 32'd32768) ? OW'(16'h8000) : OW'(~qx + 32'd1);
            end else begin
                comp[k] = (qx > 32'd32767) ? OW'(16'h7fff) : OW'(qx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero_dly       <= {r_zero_dly[F-1:0], root_side.zero};
        r_out.degenerate <= r_zero_dly[F];
        r_out.normal_x   <= r_zero_dly[F] ? '0 : comp[0];
        r_out.normal_y   <= r_zero_dly[F] ? '0 : comp[1];
        r_out.normal_z   <= r_zero_dly[F] ? '0 : comp[2];
    end

    assign o_valid = r_vld[LAT-1];
    assign o_out   = r_out;

    // A degenerate triangle must report an all-zero normal.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.degenerate |->
            o_out.normal_x == '0 && o_out.normal_y == '0 && o_out.normal_z == '0)
        else $error("degenerate beat with nonzero normal");

    // A real triangle has at least one nonzero component.
    a_nondegen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.degenerate |->
            o_out.normal_x != '0 || o_out.normal_y != '0 || o_out.normal_z != '0)
        else $error("nondegenerate beat with zero normal");

    // The input side never stalls, so every start beat is taken.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !busy)
        else $error("busy raised against a start");
endmodule

FILE: sv/tun_cross.sv
// ----------------------------------------------------------------------------
// Cross product lane
// Forms one cross product component exactly and its square, four stages deep.
// ----------------------------------------------------------------------------
module tun_cross (
    input  logic                              i_clk,
    input  logic signed [tun_pkg::DiffW-1:0]  i_x1,
    input  logic signed [tun_pkg::DiffW-1:0]  i_y1,
    input  logic signed [tun_pkg::DiffW-1:0]  i_x2,
    input  logic signed [tun_pkg::DiffW-1:0]  i_y2,
    output logic [tun_pkg::MagW-1:0]          o_mag,
    output logic                              o_neg,
    output logic [tun_pkg::SqW-1:0]           o_sq
);
    localparam int PW = tun_pkg::ProdW;
    localparam int MW = tun_pkg::MagW;
    localparam int HW = tun_pkg::HalfW;
    localparam int QW = tun_pkg::SqW;

    logic signed [PW-1:0] r_p, r_q;
    logic signed [PW:0]   diff;
    logic [MW-1:0]        r_mag_b, r_mag_c, r_mag_d;
    logic                 r_neg_b, r_neg_c, r_neg_d;
    logic [HW-1:0]        hi, lo;
    logic [2*HW-1:0]      r_hh, r_hl, r_ll;
    logic [QW-1:0]        r_sq;

    assign diff = (PW+1)'(r_p) - (PW+1)'(r_q);
    assign hi   = HW'(r_mag_b >> HW);
    assign lo   = r_mag_b[HW-1:0];

    always_ff @(posedge i_clk) begin
        r_p     <= PW'(i_x1) * PW'(i_y1);
        r_q     <= PW'(i_x2) * PW'(i_y2);
        r_neg_b <= diff[PW];
        r_mag_b <= diff[PW] ? MW'(-diff) : MW'(diff);
        r_hh    <= hi * hi;
        r_hl    <= hi * lo;
        r_ll    <= lo * lo;
        r_mag_c <= r_mag_b;
        r_neg_c <= r_neg_b;
        r_sq    <= (QW'(r_hh) << (2*HW)) + (QW'(r_hl) << (HW+1)) + QW'(r_ll);
        r_mag_d <= r_mag_c;
        r_neg_d <= r_neg_c;
    end

    assign o_mag = r_mag_d;
    assign o_neg = r_neg_d;
    assign o_sq  = r_sq;
endmodule

FILE: sv/tun_sqrt.sv
// ----------------------------------------------------------------------------
// Integer square root pipeline
// Settles one root bit per stage and carries the lane results alongside.
// ----------------------------------------------------------------------------
module tun_sqrt (
    input  logic                      i_clk,
    input  logic [tun_pkg::SumW-1:0]  i_s,
    input  tun_pkg::t_side            i_side,
    output logic [tun_pkg::RootW-1:0] o_root,
    output tun_pkg::t_side            o_side
);
    localparam int SW = tun_pkg::SumW;
    localparam int LW = tun_pkg::RootW;

    logic [SW-1:0]   r_rem  [LW];
    logic [LW-1:0]   r_root [LW];
    tun_pkg::t_side  r_side [LW];

    for (genvar i = 0; i < LW; i++) begin : g_stg
        localparam int B = LW - 1 - i;
        logic [SW-1:0]  cur_rem;
        logic [SW-1:0]  trial;
        logic [LW-1:0]  cur_root;
        tun_pkg::t_side cur_side;

        if (i == 0) begin : g_first
            assign cur_rem  = i_s;
            assign cur_root = '0;
            assign cur_side = i_side;
        end else begin : g_next
            assign cur_rem  = r_rem[i-1];
            assign cur_root = r_root[i-1];
            assign cur_side = r_side[i-1];
        end

        assign trial = (SW'(cur_root) << (B + 1)) + (SW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (trial <= cur_rem) begin
                r_rem[i]  <= cur_rem - trial;
                r_root[i] <= cur_root | (LW'(1) << B);
            end else begin
                r_rem[i]  <= cur_rem;
                r_root[i] <= cur_root;
            end
            r_side[i] <= cur_side;
        end
    end

    assign o_root = r_root[LW-1];
    assign o_side = r_side[LW-1];
endmodule

FILE: sv/tun_div.sv
// ----------------------------------------------------------------------------
// Normalizing divider lane
// Restoring division of one component by the length, one quotient bit a stage.
// ----------------------------------------------------------------------------
module tun_div #(
    parameter int FRAC = 14
) (
    input  logic                      i_clk,
    input  logic [tun_pkg::MagW-1:0]  i_mag,
    input  logic [tun_pkg::RootW-1:0] i_len,
    input  logic                      i_neg,
    output logic [FRAC:0]             o_q,
    output logic                      o_neg
);
    localparam int LW = tun_pkg::RootW;
    localparam int RW = LW + 1;
    localparam int NS = FRAC + 1;

    logic [RW-1:0]   r_rem [NS];
    logic [LW-1:0]   r_len [NS];
    logic [FRAC:0]   r_q   [NS];
    logic            r_neg [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stg
        localparam int B = FRAC - j;
        logic [RW-1:0] cur_rem;
        logic [RW-1:0] nxt_rem;
        logic [LW-1:0] cur_len;
        logic [FRAC:0] cur_q;
        logic          cur_neg;
        logic          ge;

        if (j == 0) begin : g_first
            assign cur_rem = RW'(i_mag);
            assign cur_len = i_len;
            assign cur_q   = '0;
            assign cur_neg = i_neg;
        end else begin : g_next
            assign cur_rem = r_rem[j-1];
            assign cur_len = r_len[j-1];
            assign cur_q   = r_q[j-1];
            assign cur_neg = r_neg[j-1];
        end

        assign ge      = cur_rem >= RW'(cur_len);
        assign nxt_rem = ge ? cur_rem - RW'(cur_len) : cur_rem;

        always_ff @(posedge i_clk) begin
            r_rem[j] <= RW'(nxt_rem << 1);
            r_len[j] <= cur_len;
            r_q[j]   <= ge ? (cur_q | ((FRAC+1)'(1) << B)) : cur_q;
            r_neg[j] <= cur_neg;
        end
    end

    assign o_q   = r_q[NS-1];
    assign o_neg = r_neg[NS-1];
endmodule
